// ===== rtl/core/queue_machine_execute_unit_defines.svh =====
// Assertion macros for the queue machine execute unit checker
`ifndef QUEUE_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define QUEUE_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define QMEU_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("qmeu check failed");
`define QMEU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qmeu check failed");
`endif

// ===== rtl/core/qmeu_pkg.sv =====
// Package: types, constants and action codes of the queue machine execute unit
`timescale 1ns / 1ps
`default_nettype none
package qmeu_pkg;
    localparam int QUEUE_DEPTH = 4096;
    localparam int NUM_REGS = 26;
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int RAW = 5;
    localparam int VW = 17;
    localparam logic [VW-1:0] REG_RESET_BASE = 17'd65583;

    localparam logic [4:0] ACT_PUSH = 5'd0;
    localparam logic [4:0] ACT_ADD = 5'd1;
    localparam logic [4:0] ACT_SUB = 5'd2;
    localparam logic [4:0] ACT_MUL = 5'd3;
    localparam logic [4:0] ACT_DIV = 5'd4;
    localparam logic [4:0] ACT_MOD = 5'd5;
    localparam logic [4:0] ACT_POPREG = 5'd6;
    localparam logic [4:0] ACT_PUSHREG = 5'd7;
    localparam logic [4:0] ACT_PRPOP = 5'd8;
    localparam logic [4:0] ACT_PRREG = 5'd9;
    localparam logic [4:0] ACT_CHPOP = 5'd10;
    localparam logic [4:0] ACT_CHREG = 5'd11;
    localparam logic [4:0] ACT_JUMP = 5'd13;
    localparam logic [4:0] ACT_JZ = 5'd14;
    localparam logic [4:0] ACT_JEQ = 5'd15;
    localparam logic [4:0] ACT_JGT = 5'd16;
    localparam logic [4:0] ACT_QUIT = 5'd17;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_EMPTY = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [4:0] action;
        logic [4:0] reg_a;
        logic [4:0] reg_b;
        logic [15:0] immediate;
    } in_item_t;

    typedef struct packed {
        logic branch_taken;
        logic print_valid;
        logic print_is_char;
        logic [16:0] print_value;
        logic halt;
        logic [1:0] error_code;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic [VW-1:0] dividend;
        logic [VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [VW-1:0] quotient;
        logic [VW-1:0] remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/qmeu_divider.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module qmeu_divider (
    input  wire logic clk,
    input  wire logic rst_n,
    input  qmeu_pkg::div_req_t req,
    output qmeu_pkg::div_rsp_t rsp
);
    import qmeu_pkg::*;
    localparam int CW = $clog2(VW + 1);
    logic busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] q_reg, q_next, d_reg, d_next;
    logic [VW:0] r_reg, r_next;
    logic done_reg, done_next;
    logic [VW:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        q_next = q_reg;
        d_next = d_reg;
        r_next = r_reg;
        done_next = 1'b0;
        trial = {r_reg[VW-1:0], q_reg[VW-1]} - {1'b0, d_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = CW'(VW);
            q_next = req.dividend;
            d_next = req.divisor;
            r_next = '0;
        end
        else if (busy_reg)
        begin
            if (!trial[VW])
            begin
                r_next = trial;
                q_next = {q_reg[VW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[VW-1:0], q_reg[VW-1]};
                q_next = {q_reg[VW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        d_reg <= d_next;
        r_reg <= r_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = (d_reg == '0) ? '0 : q_reg;
    assign rsp.remainder = (d_reg == '0) ? '0 : r_reg[VW-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/qmeu_value_ram.sv =====
// Value queue storage: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module qmeu_value_ram (
    input  wire logic clk,
    input  wire logic we,
    input  wire logic [qmeu_pkg::QAW-1:0] waddr,
    input  wire logic [qmeu_pkg::VW-1:0] wdata,
    input  wire logic [qmeu_pkg::QAW-1:0] raddr,
    output logic [qmeu_pkg::VW-1:0] rdata
);
    import qmeu_pkg::*;
    logic [VW-1:0] mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/queue_machine_execute_unit.sv =====
// Top level: queue machine execute unit with sequencer and letter registers
//
// Usage:
//   in_*  channel carries one decoded instruction per beat (in_item_t).
//   out_* channel returns exactly one result beat per instruction.
//   One instruction is worked on at a time; in_stall is high while busy.
//   Work between accepted beat and result valid:
//     push, register, print, branch, quit: at most one queue pop or push
//     add, sub, mul: two queue memory reads plus write-back
//     div, mod: two queue memory reads, the 17-step divider, then write-back
//   A new instruction is taken only after the result beat has been taken.
//   The value queue is a 4096-entry synchronous RAM read one entry a cycle;
//   its contents are undefined after reset, and head and count are cleared,
//   so no clearing pass is needed. Letter registers reset to 65583 + index.
//   While out_stall is high the result beat holds and no new instruction
//   is taken.
`timescale 1ns / 1ps
`default_nettype none
module queue_machine_execute_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  qmeu_pkg::in_item_t in_data,
    output logic out_valid,
    input  wire logic out_stall,
    output qmeu_pkg::out_item_t out_data
);
    import qmeu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP1 = 3'd1;
    localparam logic [2:0] S_POP2 = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_DIV = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;
    localparam logic [2:0] S_OUT = 3'd6;

    logic [2:0] state_reg, state_next;
    in_item_t ins_reg, ins_next;
    out_item_t res_reg, res_next;
    logic [QAW-1:0] head_reg, head_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [VW-1:0] x_reg, x_next, y_reg, y_next, pv_reg, pv_next;
    logic [VW-1:0] regs_reg [NUM_REGS];
    logic pop_pend_reg, pop_pend_next, pop_ok_reg, pop_ok_next;
    logic [1:0] err_reg, err_next;
    logic [31:0] prod;

    logic ram_we;
    logic [QAW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_rdata;
    div_req_t dreq;
    div_rsp_t drsp;

    logic [VW-1:0] rv_a, rv_b;
    logic reg_we;
    logic [VW-1:0] reg_wdata;
    logic [VW-1:0] pop_val;

    qmeu_value_ram u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(pv_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    qmeu_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign rv_a = (ins_reg.reg_a < RAW'(NUM_REGS)) ? regs_reg[ins_reg.reg_a] : '0;
    assign rv_b = (ins_reg.reg_b < RAW'(NUM_REGS)) ? regs_reg[ins_reg.reg_b] : '0;
    assign pop_val = pop_ok_reg ? ram_rdata : '0;
    assign prod = 32'(x_reg[15:0]) * 32'(y_reg[15:0]);
    assign ram_raddr = head_reg;
    assign ram_waddr = QAW'(32'(head_reg) + 32'(count_reg));

    always_comb
    begin
        state_next = state_reg;
        ins_next = ins_reg;
        res_next = res_reg;
        head_next = head_reg;
        count_next = count_reg;
        x_next = x_reg;
        y_next = y_reg;
        pv_next = pv_reg;
        pop_pend_next = 1'b0;
        pop_ok_next = pop_ok_reg;
        err_next = err_reg;
        ram_we = 1'b0;
        reg_we = 1'b0;
        reg_wdata = pop_val;
        dreq = '0;
        dreq.dividend = x_reg;
        dreq.divisor = y_reg;
        if (pop_pend_reg && count_reg == '0)
            pop_ok_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ins_next = in_data;
                    err_next = ERR_OK;
                    res_next = '0;
                    state_next = S_OUT;
                    case (in_data.action)
                        ACT_PUSH:
                        begin
                            pv_next = {1'b0, in_data.immediate};
                            state_next = S_PUSH;
                        end
                        ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD,
                        ACT_POPREG, ACT_PRPOP, ACT_CHPOP:
                            state_next = S_POP1;
                        ACT_PUSHREG:
                            state_next = S_PUSH;
                        default:
                            state_next = S_OUT;
                    endcase
                    if (in_data.action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV,
                                               ACT_MOD, ACT_POPREG, ACT_PRPOP,
                                               ACT_CHPOP})
                    begin
                        pop_ok_next = (count_reg != '0);
                        if (count_reg != '0)
                        begin
                            head_next = head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            err_next = ERR_EMPTY;
                        pop_pend_next = 1'b1;
                    end
                end
            end
            S_POP1:
            begin
                x_next = pop_val;
                case (ins_reg.action)
                    ACT_POPREG:
                    begin
                        reg_we = 1'b1;
                        state_next = S_OUT;
                    end
                    ACT_PRPOP:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = pop_val;
                        state_next = S_OUT;
                    end
                    ACT_CHPOP:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_is_char = 1'b1;
                        res_next.print_value = {9'd0, pop_val[7:0]};
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        pop_ok_next = (count_reg != '0);
                        if (count_reg != '0)
                        begin
                            head_next = head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                        else
                            err_next = ERR_EMPTY;
                        pop_pend_next = 1'b1;
                        state_next = S_POP2;
                    end
                endcase
            end
            S_POP2:
            begin
                y_next = pop_val;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                state_next = S_PUSH;
                case (ins_reg.action)
                    ACT_ADD: pv_next = {1'b0, x_reg[15:0] + y_reg[15:0]};
                    ACT_SUB: pv_next = {1'b0, x_reg[15:0] - y_reg[15:0]};
                    ACT_MUL: pv_next = {1'b0, prod[15:0]};
                    default:
                    begin
                        dreq.start = 1'b1;
                        state_next = S_DIV;
                    end
                endcase
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    pv_next = (ins_reg.action == ACT_DIV) ? drsp.quotient
                                                          : drsp.remainder;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (ins_reg.action == ACT_PUSHREG)
                    pv_next = rv_a;
                if (ins_reg.action == ACT_PUSHREG && pv_reg != rv_a)
                    state_next = S_PUSH;
                else
                begin
                    if (count_reg < QCW'(QUEUE_DEPTH))
                    begin
                        ram_we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (err_reg == ERR_OK)
                        err_next = ERR_FULL;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                res_next.error_code = err_reg;
                case (ins_reg.action)
                    ACT_PRREG:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = rv_a;
                    end
                    ACT_CHREG:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_is_char = 1'b1;
                        res_next.print_value = {9'd0, rv_a[7:0]};
                    end
                    ACT_JUMP: res_next.branch_taken = 1'b1;
                    ACT_JZ: res_next.branch_taken = (rv_a == '0);
                    ACT_JEQ: res_next.branch_taken = (rv_a == rv_b);
                    ACT_JGT: res_next.branch_taken = (rv_a > rv_b);
                    ACT_QUIT: res_next.halt = 1'b1;
                    default: ;
                endcase
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic ov_reg, ov_next;
    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        if (state_reg == S_OUT)
            ov_next = 1'b1;
    end

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data = res_reg;

    logic [2:0] state_gated;
    always_comb
    begin
        state_gated = state_next;
        if (state_reg == S_IDLE && (ov_reg || !in_valid))
            state_gated = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg <= '0;
            count_reg <= '0;
            ov_reg <= 1'b0;
            pop_pend_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
                regs_reg[i] <= REG_RESET_BASE + VW'(i);
        end
        else
        begin
            state_reg <= state_gated;
            ov_reg <= ov_next;
            if (!(state_reg == S_IDLE && ov_reg))
            begin
                head_reg <= head_next;
                count_reg <= count_next;
                pop_pend_reg <= pop_pend_next;
            end
            if (reg_we && ins_reg.reg_a < RAW'(NUM_REGS))
                regs_reg[ins_reg.reg_a] <= reg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!(state_reg == S_IDLE && ov_reg))
        begin
            ins_reg <= ins_next;
            res_reg <= res_next;
            x_reg <= x_next;
            y_reg <= y_next;
            pv_reg <= pv_next;
            pop_ok_reg <= pop_ok_next;
            err_reg <= err_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/qmeu_checker.sv =====
// Port-level checker for the queue machine execute unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "queue_machine_execute_unit_defines.svh"
module qmeu_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire qmeu_pkg::out_item_t out_data
);
    import qmeu_pkg::*;
    `QMEU_ASSERT(a_no_take_while_out, !(out_valid && !in_stall))
    `QMEU_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `QMEU_ASSERT(a_err_range, !out_valid || out_data.error_code != 2'd3)
    `QMEU_ASSERT(a_char_range, !(out_valid && out_data.print_is_char) || out_data.print_value[16:8] == '0)
    `QMEU_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
endmodule
bind queue_machine_execute_unit qmeu_checker u_qmeu_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
